// ===== src/ccfp_pkg.sv =====
// ============================================================================
// Circumcircle package
// Widths, pipeline payload types and the per-stage step functions shared by
// the circumcircle datapath.
// ============================================================================
`default_nettype none

package ccfp_pkg;

    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 8;

    localparam int CFG_W   = 13;
    localparam int CIDX_W  = 1;
    localparam int OUT_W   = 16;

    // Arithmetic widths, all derived from the coordinate width.
    localparam int DIF_W   = COORD_BITS + 1;
    localparam int SUM_W   = COORD_BITS + 1;
    localparam int PRD_W   = DIF_W + SUM_W + 1;
    localparam int RD_W    = PRD_W + 1;
    localparam int DP_W    = 2 * DIF_W;
    localparam int DET_W   = DP_W + 1;
    localparam int DEN_W   = DET_W + 1;
    localparam int MP_W    = RD_W + DIF_W;
    localparam int NUM_W   = MP_W + 1;

    // Integer quotient bits kept by the divider; larger quotients overflow.
    localparam int INT_W   = 19;
    localparam int Q_W     = INT_W + FRAC_BITS;
    localparam int OVC_W   = DEN_W + INT_W;
    localparam int QLIM    = 1 << 17;

    localparam int DX_W    = Q_W + 2;
    localparam int DM_W    = 16 + FRAC_BITS;
    localparam int SQ_W    = 2 * DM_W;
    localparam int RT_W    = DM_W;
    localparam int REM_W   = RT_W + 2;

    typedef enum logic [CIDX_W-1:0] {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [Q_W-1:0]   quo;
    } t_div_pair;

    typedef struct packed {
        t_div_pair               px;
        t_div_pair               py;
        logic [DEN_W-1:0]        denm;
        logic                    negx;
        logic                    negy;
        logic                    ovfx;
        logic                    ovfy;
        logic                    deg;
        logic [COORD_BITS-1:0]   xi;
        logic [COORD_BITS-1:0]   yi;
    } t_div;

    typedef struct packed {
        logic [SQ_W-1:0]         val;
        logic [RT_W-1:0]         root;
        logic [REM_W-1:0]        rem;
        logic                    far;
        logic signed [OUT_W-1:0] cx;
        logic signed [OUT_W-1:0] cy;
        logic                    satc;
        logic                    in_img;
        logic                    deg;
    } t_sq;

    typedef struct packed {
        logic signed [OUT_W-1:0] val;
        logic                    sat;
    } t_clip;

    // One restoring division step: bring down the next dividend bit.
    function automatic t_div_pair div_step(t_div_pair p, logic [DEN_W-1:0] d);
        logic [DEN_W:0] t;
        logic           ge;
        t_div_pair      r;
        t  = {p.rem, p.quo[Q_W-1]};
        ge = (t >= {1'b0, d});
        r.rem = ge ? DEN_W'(t - {1'b0, d}) : DEN_W'(t);
        r.quo = {p.quo[Q_W-2:0], ge};
        return r;
    endfunction

    // One divider stage: both coordinates advance by one quotient bit.
    function automatic t_div div_next(t_div s);
        t_div r;
        r    = s;
        r.px = div_step(s.px, s.denm);
        r.py = div_step(s.py, s.denm);
        return r;
    endfunction

    // One digit of the square root: bring down two radicand bits.
    function automatic t_sq sqrt_step(t_sq s);
        logic [REM_W+1:0] t;
        logic [REM_W+1:0] trial;
        t_sq              r;
        r     = s;
        t     = {s.rem, s.val[SQ_W-1:SQ_W-2]};
        trial = (REM_W+2)'({s.root, 2'b01});
        if (t >= trial) begin
            r.rem  = REM_W'(t - trial);
            r.root = {s.root[RT_W-2:0], 1'b1};
        end else begin
            r.rem  = REM_W'(t);
            r.root = {s.root[RT_W-2:0], 1'b0};
        end
        r.val = s.val << 2;
        return r;
    endfunction

    // Clip a signed center given as sign and integer magnitude.
    function automatic t_clip clip_center(logic neg, logic ovf, logic [INT_W-1:0] qm);
        t_clip r;
        r.sat = 1'b0;
        if (ovf) begin
            r.sat = 1'b1;
            r.val = neg ? OUT_W'(16'sh8000) : OUT_W'(16'sh7fff);
        end else if (!neg && qm > INT_W'(32767)) begin
            r.sat = 1'b1;
            r.val = OUT_W'(16'sh7fff);
        end else if (neg && qm > INT_W'(32768)) begin
            r.sat = 1'b1;
            r.val = OUT_W'(16'sh8000);
        end else begin
            r.val = neg ? -$signed(OUT_W'(qm)) : $signed(OUT_W'(qm));
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/circumcircle_from_three_points.sv =====
// ============================================================================
// Circle through three points
// Fully pipelined circumcircle: center by exact division, radius by an
// integer square root, with degenerate, saturation and inside-image flags.
// ============================================================================
// Each item carries three pixel points; the block returns the center of the
// circle through them (truncated toward zero, clipped to 16 signed bits) and
// its radius (floored, clipped to 16 unsigned bits). Collinear points raise
// the degenerate flag and zero every other field. The pipeline takes one item
// per clock while the output is not stalled and passes it through six stages
// of products and sums, one stage per quotient bit of the restoring divider
// (both center coordinates in parallel), three stages of squaring, one stage
// per root bit of the square root, and the output register. A stall on the
// output freezes every stage together, so no item is lost or repeated. The
// user must write the image bounds through the configuration port only while
// the pipeline is empty; the block itself does not enforce this.
`default_nettype none

module circumcircle_from_three_points (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [ccfp_pkg::CIDX_W-1:0]        i_cfg_index,
    input  wire logic [ccfp_pkg::CFG_W-1:0]         i_cfg_wdata,
    input  wire logic                               i_in_valid,
    output      logic                               o_in_ready,
    input  wire logic [ccfp_pkg::COORD_BITS-1:0]    i_first_x,
    input  wire logic [ccfp_pkg::COORD_BITS-1:0]    i_first_y,
    input  wire logic [ccfp_pkg::COORD_BITS-1:0]    i_second_x,
    input  wire logic [ccfp_pkg::COORD_BITS-1:0]    i_second_y,
    input  wire logic [ccfp_pkg::COORD_BITS-1:0]    i_third_x,
    input  wire logic [ccfp_pkg::COORD_BITS-1:0]    i_third_y,
    output      logic                               o_out_valid,
    input  wire logic                               i_out_ready,
    output      logic signed [ccfp_pkg::OUT_W-1:0]  o_center_x,
    output      logic signed [ccfp_pkg::OUT_W-1:0]  o_center_y,
    output      logic [ccfp_pkg::OUT_W-1:0]         o_radius,
    output      logic                               o_degenerate,
    output      logic                               o_saturated,
    output      logic                               o_inside_image
);

    localparam int CW = ccfp_pkg::COORD_BITS;
    localparam int F  = ccfp_pkg::FRAC_BITS;
    localparam int QW = ccfp_pkg::Q_W;
    localparam int RW = ccfp_pkg::RT_W;

    // Valid bits: six front stages, divider, three squaring stages, root.
    localparam int NV = 6 + QW + 3 + RW;

    logic en;
    logic [NV-1:0] r_v;
    logic r_out_valid;

    assign en          = !r_out_valid || i_out_ready;
    assign o_in_ready  = en;
    assign o_out_valid = r_out_valid;

    // Configuration registers.
    logic [ccfp_pkg::CFG_W-1:0] r_image_width;
    logic [ccfp_pkg::CFG_W-1:0] r_image_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= ccfp_pkg::CFG_W'(640);
            r_image_height <= ccfp_pkg::CFG_W'(480);
        end else if (i_cfg_we) begin
            case (ccfp_pkg::t_reg_idx'(i_cfg_index))
                ccfp_pkg::REG_WIDTH:  r_image_width  <= i_cfg_wdata;
                ccfp_pkg::REG_HEIGHT: r_image_height <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Valid chain moves with the data under the common enable.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v         <= '0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_v         <= {r_v[NV-2:0], i_in_valid};
            r_out_valid <= r_v[NV-1];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: point differences relative to the first point and sums.
    // ------------------------------------------------------------------
    logic [CW-1:0] r1_xi, r1_yi;
    logic signed [ccfp_pkg::DIF_W-1:0] r1_a, r1_b, r1_c, r1_d;
    logic [ccfp_pkg::SUM_W-1:0] r1_sxj, r1_syj, r1_sxk, r1_syk;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_xi  <= i_first_x;
            r1_yi  <= i_first_y;
            r1_a   <= $signed({1'b0, i_second_x}) - $signed({1'b0, i_first_x});
            r1_b   <= $signed({1'b0, i_second_y}) - $signed({1'b0, i_first_y});
            r1_c   <= $signed({1'b0, i_third_x})  - $signed({1'b0, i_first_x});
            r1_d   <= $signed({1'b0, i_third_y})  - $signed({1'b0, i_first_y});
            r1_sxj <= {1'b0, i_second_x} + {1'b0, i_first_x};
            r1_syj <= {1'b0, i_second_y} + {1'b0, i_first_y};
            r1_sxk <= {1'b0, i_third_x}  + {1'b0, i_first_x};
            r1_syk <= {1'b0, i_third_y}  + {1'b0, i_first_y};
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: determinant products and the squared-radius differences
    // written as (xj - xi)(xj + xi) + (yj - yi)(yj + yi).
    // ------------------------------------------------------------------
    logic [CW-1:0] r2_xi, r2_yi;
    logic signed [ccfp_pkg::DIF_W-1:0] r2_a, r2_b, r2_c, r2_d;
    logic signed [ccfp_pkg::DP_W-1:0]  r2_pd1, r2_pd2;
    logic signed [ccfp_pkg::PRD_W-1:0] r2_pa, r2_pb, r2_pc, r2_pd;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_xi  <= r1_xi;
            r2_yi  <= r1_yi;
            r2_a   <= r1_a;
            r2_b   <= r1_b;
            r2_c   <= r1_c;
            r2_d   <= r1_d;
            r2_pd1 <= r1_a * r1_d;
            r2_pd2 <= r1_c * r1_b;
            r2_pa  <= r1_a * $signed({1'b0, r1_sxj});
            r2_pb  <= r1_b * $signed({1'b0, r1_syj});
            r2_pc  <= r1_c * $signed({1'b0, r1_sxk});
            r2_pd  <= r1_d * $signed({1'b0, r1_syk});
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: determinant and the two squared-radius differences.
    // ------------------------------------------------------------------
    logic [CW-1:0] r3_xi, r3_yi;
    logic signed [ccfp_pkg::DIF_W-1:0] r3_a, r3_b, r3_c, r3_d;
    logic signed [ccfp_pkg::DET_W-1:0] r3_det;
    logic signed [ccfp_pkg::RD_W-1:0]  r3_rj, r3_rk;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_xi  <= r2_xi;
            r3_yi  <= r2_yi;
            r3_a   <= r2_a;
            r3_b   <= r2_b;
            r3_c   <= r2_c;
            r3_d   <= r2_d;
            r3_det <= ccfp_pkg::DET_W'(r2_pd1) - ccfp_pkg::DET_W'(r2_pd2);
            r3_rj  <= ccfp_pkg::RD_W'(r2_pa) + ccfp_pkg::RD_W'(r2_pb);
            r3_rk  <= ccfp_pkg::RD_W'(r2_pc) + ccfp_pkg::RD_W'(r2_pd);
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: numerator products.
    // ------------------------------------------------------------------
    logic [CW-1:0] r4_xi, r4_yi;
    logic signed [ccfp_pkg::DET_W-1:0] r4_det;
    logic signed [ccfp_pkg::MP_W-1:0]  r4_m1, r4_m2, r4_m3, r4_m4;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_xi  <= r3_xi;
            r4_yi  <= r3_yi;
            r4_det <= r3_det;
            r4_m1  <= r3_rj * r3_d;
            r4_m2  <= r3_rk * r3_b;
            r4_m3  <= r3_a * r3_rk;
            r4_m4  <= r3_c * r3_rj;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: numerators, denominator (twice the determinant).
    // ------------------------------------------------------------------
    logic [CW-1:0] r5_xi, r5_yi;
    logic signed [ccfp_pkg::NUM_W-1:0] r5_nx, r5_ny;
    logic signed [ccfp_pkg::DEN_W-1:0] r5_den;
    logic r5_deg;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_xi  <= r4_xi;
            r5_yi  <= r4_yi;
            r5_nx  <= ccfp_pkg::NUM_W'(r4_m1) - ccfp_pkg::NUM_W'(r4_m2);
            r5_ny  <= ccfp_pkg::NUM_W'(r4_m3) - ccfp_pkg::NUM_W'(r4_m4);
            r5_den <= {r4_det, 1'b0};
            r5_deg <= (r4_det == '0);
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: magnitudes, quotient signs and overflow test. The divider
    // works on |n| * 2^F / |den|; the fixed-point quotient truncated toward
    // zero is the integer quotient followed by the fraction bits.
    // ------------------------------------------------------------------
    logic [ccfp_pkg::NUM_W-1:0] nxm, nym;
    logic [ccfp_pkg::DEN_W-1:0] denm;
    logic [ccfp_pkg::OVC_W-1:0] den_lim;
    logic [ccfp_pkg::NUM_W+F-1:0] dvdx, dvdy;
    ccfp_pkg::t_div n_div0;

    always_comb begin
        nxm     = r5_nx[ccfp_pkg::NUM_W-1] ? ccfp_pkg::NUM_W'(-r5_nx)
                                           : ccfp_pkg::NUM_W'(r5_nx);
        nym     = r5_ny[ccfp_pkg::NUM_W-1] ? ccfp_pkg::NUM_W'(-r5_ny)
                                           : ccfp_pkg::NUM_W'(r5_ny);
        denm    = r5_den[ccfp_pkg::DEN_W-1] ? ccfp_pkg::DEN_W'(-r5_den)
                                            : ccfp_pkg::DEN_W'(r5_den);
        den_lim = ccfp_pkg::OVC_W'(denm) << ccfp_pkg::INT_W;
        dvdx    = (ccfp_pkg::NUM_W+F)'(nxm) << F;
        dvdy    = (ccfp_pkg::NUM_W+F)'(nym) << F;

        n_div0.px.rem = ccfp_pkg::DEN_W'(nxm >> ccfp_pkg::INT_W);
        n_div0.px.quo = QW'(dvdx);
        n_div0.py.rem = ccfp_pkg::DEN_W'(nym >> ccfp_pkg::INT_W);
        n_div0.py.quo = QW'(dvdy);
        n_div0.denm   = denm;
        n_div0.negx   = r5_nx[ccfp_pkg::NUM_W-1] ^ r5_den[ccfp_pkg::DEN_W-1];
        n_div0.negy   = r5_ny[ccfp_pkg::NUM_W-1] ^ r5_den[ccfp_pkg::DEN_W-1];
        n_div0.ovfx   = (ccfp_pkg::OVC_W'(nxm) >= den_lim);
        n_div0.ovfy   = (ccfp_pkg::OVC_W'(nym) >= den_lim);
        n_div0.deg    = r5_deg;
        n_div0.xi     = r5_xi;
        n_div0.yi     = r5_yi;
    end

    // ------------------------------------------------------------------
    // Divider: one quotient bit per stage for both coordinates.
    // ------------------------------------------------------------------
    ccfp_pkg::t_div r_div [QW+1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_div[0] <= n_div0;
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_div[k+1] <= ccfp_pkg::div_next(r_div[k]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage A: sign the centers, clip, inside test, offsets to point one.
    // ------------------------------------------------------------------
    ccfp_pkg::t_div dq;
    logic [ccfp_pkg::INT_W-1:0] qmx, qmy;
    logic signed [QW:0] cfx, cfy;
    logic signed [ccfp_pkg::DX_W-1:0] xis, yis;
    ccfp_pkg::t_clip clx, cly;

    always_comb begin
        dq  = r_div[QW];
        qmx = ccfp_pkg::INT_W'(dq.px.quo >> F);
        qmy = ccfp_pkg::INT_W'(dq.py.quo >> F);
        cfx = dq.negx ? -$signed({1'b0, dq.px.quo}) : $signed({1'b0, dq.px.quo});
        cfy = dq.negy ? -$signed({1'b0, dq.py.quo}) : $signed({1'b0, dq.py.quo});
        xis = $signed(ccfp_pkg::DX_W'(dq.xi) << F);
        yis = $signed(ccfp_pkg::DX_W'(dq.yi) << F);
        clx = ccfp_pkg::clip_center(dq.negx, dq.ovfx, qmx);
        cly = ccfp_pkg::clip_center(dq.negy, dq.ovfy, qmy);
    end

    logic signed [ccfp_pkg::DX_W-1:0] ra_dx, ra_dy;
    logic ra_big, ra_satc, ra_inside, ra_deg;
    logic signed [ccfp_pkg::OUT_W-1:0] ra_cx, ra_cy;

    always_ff @(posedge i_clk) begin
        if (en) begin
            ra_dx     <= xis - ccfp_pkg::DX_W'(cfx);
            ra_dy     <= yis - ccfp_pkg::DX_W'(cfy);
            ra_big    <= dq.ovfx || dq.ovfy ||
                         (qmx > ccfp_pkg::INT_W'(ccfp_pkg::QLIM)) ||
                         (qmy > ccfp_pkg::INT_W'(ccfp_pkg::QLIM));
            ra_cx     <= clx.val;
            ra_cy     <= cly.val;
            ra_satc   <= clx.sat || cly.sat;
            ra_inside <= !dq.ovfx && !dq.negx && (qmx != '0) &&
                         (qmx < ccfp_pkg::INT_W'(r_image_width)) &&
                         !dq.ovfy && !dq.negy && (qmy != '0) &&
                         (qmy < ccfp_pkg::INT_W'(r_image_height));
            ra_deg    <= dq.deg;
        end
    end

    // ------------------------------------------------------------------
    // Stage B: range check on the offsets and squaring.
    // ------------------------------------------------------------------
    logic [ccfp_pkg::DX_W-1:0] dxm, dym;

    always_comb begin
        dxm = ra_dx[ccfp_pkg::DX_W-1] ? ccfp_pkg::DX_W'(-ra_dx) : ccfp_pkg::DX_W'(ra_dx);
        dym = ra_dy[ccfp_pkg::DX_W-1] ? ccfp_pkg::DX_W'(-ra_dy) : ccfp_pkg::DX_W'(ra_dy);
    end

    logic [ccfp_pkg::SQ_W-1:0] rb_dx2, rb_dy2;
    logic rb_far, rb_satc, rb_inside, rb_deg;
    logic signed [ccfp_pkg::OUT_W-1:0] rb_cx, rb_cy;

    always_ff @(posedge i_clk) begin
        if (en) begin
            rb_dx2    <= ccfp_pkg::DM_W'(dxm) * ccfp_pkg::DM_W'(dxm);
            rb_dy2    <= ccfp_pkg::DM_W'(dym) * ccfp_pkg::DM_W'(dym);
            rb_far    <= ra_big || ((dxm >> ccfp_pkg::DM_W) != '0) ||
                         ((dym >> ccfp_pkg::DM_W) != '0);
            rb_cx     <= ra_cx;
            rb_cy     <= ra_cy;
            rb_satc   <= ra_satc;
            rb_inside <= ra_inside;
            rb_deg    <= ra_deg;
        end
    end

    // ------------------------------------------------------------------
    // Stage C: squared radius and its range check; seeds the square root.
    // ------------------------------------------------------------------
    logic [ccfp_pkg::SQ_W:0] sum2;
    ccfp_pkg::t_sq n_sq0;

    always_comb begin
        sum2          = {1'b0, rb_dx2} + {1'b0, rb_dy2};
        n_sq0.val     = sum2[ccfp_pkg::SQ_W-1:0];
        n_sq0.root    = '0;
        n_sq0.rem     = '0;
        n_sq0.far     = rb_far || sum2[ccfp_pkg::SQ_W];
        n_sq0.cx      = rb_cx;
        n_sq0.cy      = rb_cy;
        n_sq0.satc    = rb_satc;
        n_sq0.in_img  = rb_inside;
        n_sq0.deg     = rb_deg;
    end

    // ------------------------------------------------------------------
    // Square root: one root bit per stage.
    // ------------------------------------------------------------------
    ccfp_pkg::t_sq r_sq [RW+1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq[0] <= n_sq0;
        end
    end

    for (genvar k = 0; k < RW; k++) begin : g_sqrt
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq[k+1] <= ccfp_pkg::sqrt_step(r_sq[k]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register: drop the fraction bits of the root, apply flags.
    // ------------------------------------------------------------------
    ccfp_pkg::t_sq sq;
    assign sq = r_sq[RW];

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (sq.deg) begin
                o_center_x     <= '0;
                o_center_y     <= '0;
                o_radius       <= '0;
                o_degenerate   <= 1'b1;
                o_saturated    <= 1'b0;
                o_inside_image <= 1'b0;
            end else begin
                o_center_x     <= sq.cx;
                o_center_y     <= sq.cy;
                o_radius       <= sq.far ? '1 : ccfp_pkg::OUT_W'(sq.root >> F);
                o_degenerate   <= 1'b0;
                o_saturated    <= sq.satc || sq.far;
                o_inside_image <= sq.in_img;
            end
        end
    end

endmodule

`default_nettype wire
